>>> rtl/tin_pkg.sv
// ----------------------------------------------------------------------------
// tin_pkg
// Shared types and codes for the Telnet IAC option negotiator.
// ----------------------------------------------------------------------------
`default_nettype none

package tin_pkg;

   // Telnet command and option codes
   localparam logic [7:0] CMD_IAC  = 8'hFF;
   localparam logic [7:0] CMD_SB   = 8'hFA;
   localparam logic [7:0] CMD_WILL = 8'hFB;
   localparam logic [7:0] CMD_WONT = 8'hFC;
   localparam logic [7:0] CMD_DO   = 8'hFD;
   localparam logic [7:0] CMD_DONT = 8'hFE;
   localparam logic [7:0] OPT_ECHO = 8'h01;
   localparam logic [7:0] OPT_SGA  = 8'h03;

   // Result kinds
   localparam logic [1:0] KIND_DATA     = 2'd0;
   localparam logic [1:0] KIND_ESC      = 2'd1;
   localparam logic [1:0] KIND_CONSUMED = 2'd2;
   localparam logic [1:0] KIND_REPLY    = 2'd3;

   // Stored verb codes (verb minus WILL)
   localparam logic [1:0] VERB_WILL = 2'd0;
   localparam logic [1:0] VERB_WONT = 2'd1;
   localparam logic [1:0] VERB_DO   = 2'd2;
   localparam logic [1:0] VERB_DONT = 2'd3;

   // One classified input item as it travels from front to back
   typedef struct packed {
      logic       is_reply;   // expands to IAC, verb, option
      logic [1:0] kind;
      logic [7:0] value;      // data byte, or option byte for a reply
      logic [7:0] verb;       // reply verb
   } entry_type;

   // Queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

>>> rtl/tin_front.sv
// ----------------------------------------------------------------------------
// tin_front
// Accepts received bytes, tracks the IAC parse state and classifies each
// item into a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tin_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_rx_byte,
   input  wire tin_pkg::queue_status_type q_status,
   output logic                           push,
   output tin_pkg::entry_type             push_entry
);

   typedef enum logic [1:0] {
      ST_NORMAL = 2'd0,
      ST_IAC    = 2'd1,
      ST_VERB   = 2'd2,
      ST_SB     = 2'd3
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  verb_ff, verb_in;
   logic [7:0]  reply_verb;

   // Hold the input while the queue is full
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // Pick the reply verb for the pending verb and this option
   always_comb begin
      case (verb_ff)
         tin_pkg::VERB_WILL: reply_verb =
            (req_rx_byte == tin_pkg::OPT_SGA || req_rx_byte == tin_pkg::OPT_ECHO)
            ? tin_pkg::CMD_DO : tin_pkg::CMD_DONT;
         tin_pkg::VERB_DO: reply_verb =
            (req_rx_byte == tin_pkg::OPT_SGA) ? tin_pkg::CMD_WILL : tin_pkg::CMD_WONT;
         tin_pkg::VERB_WONT: reply_verb = tin_pkg::CMD_DONT;
         default:            reply_verb = tin_pkg::CMD_WONT;
      endcase
   end

   // Classify the byte and work out the next parse state
   always_comb begin
      state_in            = state_ff;
      verb_in             = verb_ff;
      push_entry.is_reply = 1'b0;
      push_entry.kind     = tin_pkg::KIND_CONSUMED;
      push_entry.value    = 8'h00;
      push_entry.verb     = reply_verb;
      case (state_ff)
         ST_NORMAL: begin
            if (req_rx_byte == tin_pkg::CMD_IAC) begin
               state_in = ST_IAC;
            end else begin
               push_entry.kind  = tin_pkg::KIND_DATA;
               push_entry.value = req_rx_byte;
            end
         end
         ST_IAC: begin
            if (req_rx_byte == tin_pkg::CMD_IAC) begin
               state_in         = ST_NORMAL;
               push_entry.kind  = tin_pkg::KIND_ESC;
               push_entry.value = tin_pkg::CMD_IAC;
            end else if (req_rx_byte == tin_pkg::CMD_SB) begin
               state_in = ST_SB;
            end else if (req_rx_byte >= tin_pkg::CMD_WILL
                         && req_rx_byte <= tin_pkg::CMD_DONT) begin
               state_in = ST_VERB;
               verb_in  = 2'(req_rx_byte - tin_pkg::CMD_WILL);
            end else begin
               state_in = ST_NORMAL;
            end
         end
         ST_VERB: begin
            state_in            = ST_NORMAL;
            push_entry.is_reply = 1'b1;
            push_entry.kind     = tin_pkg::KIND_REPLY;
            push_entry.value    = req_rx_byte;
         end
         default: begin
            if (req_rx_byte == tin_pkg::CMD_IAC) begin
               state_in = ST_IAC;
            end
         end
      endcase
   end

   // Advance the parse state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_NORMAL;
         verb_ff  <= 2'd0;
      end else if (push) begin
         state_ff <= state_in;
         verb_ff  <= verb_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/tin_queue.sv
// ----------------------------------------------------------------------------
// tin_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tin_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire tin_pkg::entry_type   push_entry,
   input  wire logic                 pop,
   output tin_pkg::entry_type        head,
   output tin_pkg::queue_status_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   tin_pkg::entry_type slot_ff [DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff,  count_in;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> rtl/tin_back.sv
// ----------------------------------------------------------------------------
// tin_back
// Expands queued items into result items and drives the registered
// result channel. A reply becomes three items: IAC, verb, option.
// ----------------------------------------------------------------------------
`default_nettype none

module tin_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire tin_pkg::entry_type        head,
   input  wire tin_pkg::queue_status_type q_status,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [1:0]                     rsp_kind,
   output logic [7:0]                     rsp_byte_value,
   output logic                           rsp_last
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_byte_value_ff, rsp_byte_value_in;
   logic       rsp_last_ff, rsp_last_in;
   logic [1:0] beat_ff, beat_in;
   logic       out_free;
   logic       issue;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign issue    = out_free && !q_status.empty;

   // Select the next result item and drop the head after its final one
   always_comb begin
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_kind_in       = rsp_kind_ff;
      rsp_byte_value_in = rsp_byte_value_ff;
      rsp_last_in       = rsp_last_ff;
      beat_in           = beat_ff;
      pop               = 1'b0;
      if (issue) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = head.kind;
         if (head.is_reply) begin
            case (beat_ff)
               2'd0: begin
                  rsp_byte_value_in = tin_pkg::CMD_IAC;
                  rsp_last_in       = 1'b0;
                  beat_in           = 2'd1;
               end
               2'd1: begin
                  rsp_byte_value_in = head.verb;
                  rsp_last_in       = 1'b0;
                  beat_in           = 2'd2;
               end
               default: begin
                  rsp_byte_value_in = head.value;
                  rsp_last_in       = 1'b1;
                  beat_in           = 2'd0;
                  pop               = 1'b1;
               end
            endcase
         end else begin
            rsp_byte_value_in = head.value;
            rsp_last_in       = 1'b1;
            beat_in           = 2'd0;
            pop               = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         beat_ff      <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         beat_ff      <= beat_in;
      end
   end

   // Hold the payload while stalled
   always_ff @(posedge clock) begin
      rsp_kind_ff       <= rsp_kind_in;
      rsp_byte_value_ff <= rsp_byte_value_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_byte_value = rsp_byte_value_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/telnet_iac_option_negotiator.sv
// ----------------------------------------------------------------------------
// telnet_iac_option_negotiator
// Telnet receive parser: passes data, unescapes IAC IAC, consumes commands
// and answers WILL/WONT/DO/DONT with a three-byte reply.
// ----------------------------------------------------------------------------
// One received byte is accepted per clock cycle while the queue is not full.
// Each byte yields one result item, except an option byte after a negotiation
// verb, which yields three (IAC, reply verb, option) with last set on the
// third; the result register issues one item per cycle while not stalled.
// A queue of QUEUE_DEPTH classified items sits between the parser and the
// output stage, so the input keeps flowing while a reply drains or the
// output is stalled; req_stall rises only when that queue is full.
`default_nettype none

module telnet_iac_option_negotiator #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_byte_value,
   output logic            rsp_last
);

   tin_pkg::entry_type        push_entry;
   tin_pkg::entry_type        head;
   tin_pkg::queue_status_type q_status;
   logic                      push;
   logic                      pop;

   // Parse and classify
   tin_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   // Decouple front from back
   tin_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // Expand and issue results
   tin_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_byte_value (rsp_byte_value),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

>>> tb/telnet_iac_option_negotiator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// telnet_iac_option_negotiator_test
// Self-checking bench for the Telnet IAC parser and option negotiator.
// A short table of hand-picked byte sequences is followed by a random stream
// of well-formed command sequences mixed with noise. Every accepted byte is
// run through a local parser model, and each result item from the block is
// compared field by field with the oldest predicted one. Both channels idle
// and stall at random, with stretches that run at full rate.
// ----------------------------------------------------------------------------

module telnet_iac_option_negotiator_test;

   localparam int RANDOM_ITEMS = 348;
   localparam int MAX_WAIT     = 6;
   localparam int DRAIN_CYCLES = 16;
   localparam int WATCHDOG     = 2000;
   localparam int REPORT_LIMIT = 10;

   // Parser phase tracked by the local model
   typedef enum logic [1:0] {
      PH_DATA, PH_AFTER_IAC, PH_AFTER_VERB, PH_SUBNEG
   } parse_phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic       last;
   } result_type;

   // One stimulus byte; typed rows carry their single result written out
   typedef struct packed {
      logic [7:0] rx;
      logic       typed;
      logic [1:0] kind;
      logic [7:0] value;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 32;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // plain data, then IAC IAC
      '{8'h00,             1'b1, tin_pkg::KIND_DATA,     8'h00},
      '{tin_pkg::CMD_IAC,  1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{tin_pkg::CMD_IAC,  1'b1, tin_pkg::KIND_ESC,      8'hFF},
      // WILL SGA, WILL ECHO, WILL of another option
      '{tin_pkg::CMD_IAC,  1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{tin_pkg::CMD_WILL, 1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{tin_pkg::OPT_SGA,  1'b0, tin_pkg::KIND_DATA,     8'h00},
      '{tin_pkg::CMD_IAC,  1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{tin_pkg::CMD_WILL, 1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{tin_pkg::OPT_ECHO, 1'b0, tin_pkg::KIND_DATA,     8'h00},
      '{tin_pkg::CMD_IAC,  1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{tin_pkg::CMD_WILL, 1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{8'hFF,             1'b0, tin_pkg::KIND_DATA,     8'h00},
      // DO SGA, DO of another option
      '{tin_pkg::CMD_IAC,  1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{tin_pkg::CMD_DO,   1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{tin_pkg::OPT_SGA,  1'b0, tin_pkg::KIND_DATA,     8'h00},
      '{tin_pkg::CMD_IAC,  1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{tin_pkg::CMD_DO,   1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{8'h00,             1'b0, tin_pkg::KIND_DATA,     8'h00},
      // WONT and DONT
      '{tin_pkg::CMD_IAC,  1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{tin_pkg::CMD_WONT, 1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{8'h80,             1'b0, tin_pkg::KIND_DATA,     8'h00},
      '{tin_pkg::CMD_IAC,  1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{tin_pkg::CMD_DONT, 1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{8'h7F,             1'b0, tin_pkg::KIND_DATA,     8'h00},
      // subnegotiation left by IAC and an unknown command
      '{tin_pkg::CMD_IAC,  1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{tin_pkg::CMD_SB,   1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{tin_pkg::CMD_IAC,  1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{8'hF1,             1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      // IAC IAC inside a subnegotiation unescapes and returns to data
      '{tin_pkg::CMD_IAC,  1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{tin_pkg::CMD_SB,   1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{tin_pkg::CMD_IAC,  1'b1, tin_pkg::KIND_CONSUMED, 8'h00},
      '{tin_pkg::CMD_IAC,  1'b1, tin_pkg::KIND_ESC,      8'hFF}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_byte_value;
   logic       rsp_last;

   parse_phase_type phase      = PH_DATA;
   logic [1:0]      held_verb  = tin_pkg::VERB_WILL;
   result_type      pending_results [$];
   stim_row_type    byte_stream [$];
   int              fault_count   = 0;
   int              results_seen  = 0;
   int              idle_cycles   = 0;
   int              stall_left    = 0;
   bit              quiet_stretch = 1'b0;

   telnet_iac_option_negotiator uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_byte_value (rsp_byte_value),
      .rsp_last       (rsp_last)
   );

   always #10 clock = ~clock;

   // Reply verb for a stored verb and its option
   function automatic logic [7:0] answer_verb(input logic [1:0] verb, input logic [7:0] opt);
      case (verb)
         tin_pkg::VERB_WILL:
            return (opt == tin_pkg::OPT_SGA || opt == tin_pkg::OPT_ECHO)
                   ? tin_pkg::CMD_DO : tin_pkg::CMD_DONT;
         tin_pkg::VERB_DO:
            return (opt == tin_pkg::OPT_SGA) ? tin_pkg::CMD_WILL : tin_pkg::CMD_WONT;
         tin_pkg::VERB_WONT:
            return tin_pkg::CMD_DONT;
         default:
            return tin_pkg::CMD_WONT;
      endcase
   endfunction

   // Advance the parser model by one byte and queue the results it yields
   function automatic void predict_negotiation(input logic [7:0] rx);
      case (phase)
         PH_DATA: begin
            if (rx == tin_pkg::CMD_IAC) begin
               phase = PH_AFTER_IAC;
               pending_results.push_back('{tin_pkg::KIND_CONSUMED, 8'h00, 1'b1});
            end else begin
               pending_results.push_back('{tin_pkg::KIND_DATA, rx, 1'b1});
            end
         end
         PH_AFTER_IAC: begin
            if (rx == tin_pkg::CMD_IAC) begin
               phase = PH_DATA;
               pending_results.push_back('{tin_pkg::KIND_ESC, 8'hFF, 1'b1});
            end else begin
               if (rx == tin_pkg::CMD_SB) begin
                  phase = PH_SUBNEG;
               end else if (rx >= tin_pkg::CMD_WILL && rx <= tin_pkg::CMD_DONT) begin
                  held_verb = 2'(rx - tin_pkg::CMD_WILL);
                  phase     = PH_AFTER_VERB;
               end else begin
                  phase = PH_DATA;
               end
               pending_results.push_back('{tin_pkg::KIND_CONSUMED, 8'h00, 1'b1});
            end
         end
         PH_AFTER_VERB: begin
            phase = PH_DATA;
            pending_results.push_back('{tin_pkg::KIND_REPLY, tin_pkg::CMD_IAC, 1'b0});
            pending_results.push_back('{tin_pkg::KIND_REPLY,
                                        answer_verb(held_verb, rx), 1'b0});
            pending_results.push_back('{tin_pkg::KIND_REPLY, rx, 1'b1});
         end
         default: begin
            if (rx == tin_pkg::CMD_IAC)
               phase = PH_AFTER_IAC;
            pending_results.push_back('{tin_pkg::KIND_CONSUMED, 8'h00, 1'b1});
         end
      endcase
   endfunction

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("%0t: %s", $realtime, msg);
   endtask

   task automatic add_byte(input logic [7:0] rx);
      byte_stream.push_back('{rx, 1'b0, tin_pkg::KIND_DATA, 8'h00});
   endtask

   // Mostly well-formed command sequences with random content, some noise
   task automatic build_random_stream();
      int pick;
      int count;
      int choice;
      logic [7:0] opt;
      while (byte_stream.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            add_byte(8'($urandom_range(0, 254)));
         end else if (pick < 45) begin
            add_byte(tin_pkg::CMD_IAC);
            add_byte(tin_pkg::CMD_IAC);
         end else if (pick < 75) begin
            choice = $urandom_range(0, 9);
            opt = (choice < 2) ? tin_pkg::OPT_SGA
                : (choice < 4) ? tin_pkg::OPT_ECHO : 8'($urandom_range(0, 255));
            add_byte(tin_pkg::CMD_IAC);
            add_byte(8'(tin_pkg::CMD_WILL + $urandom_range(0, 3)));
            add_byte(opt);
         end else if (pick < 82) begin
            add_byte(tin_pkg::CMD_IAC);
            add_byte(8'($urandom_range(0, 249)));
         end else if (pick < 92) begin
            add_byte(tin_pkg::CMD_IAC);
            add_byte(tin_pkg::CMD_SB);
            count = $urandom_range(0, 5);
            repeat (count) add_byte(8'($urandom_range(0, 254)));
            add_byte(tin_pkg::CMD_IAC);
            add_byte(($urandom_range(0, 9) == 0) ? tin_pkg::CMD_IAC : 8'hF0);
         end else begin
            add_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Drive bytes on the falling edge, predict on acceptance
   initial begin : stimulus
      stim_row_type row;
      int gap;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      foreach (DIRECTED[i]) byte_stream.push_back(DIRECTED[i]);
      build_random_stream();
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      for (int idx = 0; idx < byte_stream.size(); idx++) begin
         row = byte_stream[idx];
         quiet_stretch = (idx >= DIRECTED_ROWS) && (((idx - DIRECTED_ROWS) / 48) % 3 == 1);
         gap = quiet_stretch ? 0 : $urandom_range(0, MAX_WAIT);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid   <= 1'b1;
         req_rx_byte <= row.rx;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         predict_negotiation(row.rx);
         // a typed row stands in for the model's single result
         if (row.typed) begin
            void'(pending_results.pop_back());
            pending_results.push_back('{row.kind, row.value, 1'b1});
         end
         @(negedge clock);
      end
      req_valid     <= 1'b0;
      quiet_stretch = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         note_fault($sformatf("%0d results never arrived", pending_results.size()));
      if (fault_count == 0)
         $display("[telnet_iac_option_negotiator] OK");
      else
         $display("[telnet_iac_option_negotiator] ERROR");
      $finish;
   end

   // Hold off the result channel for the drawn number of cycles
   always @(negedge clock) begin
      if (reset || quiet_stretch) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check each accepted result against the oldest prediction; watch for hangs
   always @(posedge clock) begin : result_check
      result_type want;
      bit progress;
      progress = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall)
            progress = 1'b1;
         if (rsp_valid && !rsp_stall) begin
            progress = 1'b1;
            stall_left = $urandom_range(0, MAX_WAIT);
            if (pending_results.size() == 0) begin
               note_fault($sformatf("unexpected result kind %0d value %02h last %0b",
                                    rsp_kind, rsp_byte_value, rsp_last));
            end else begin
               want = pending_results.pop_front();
               if (rsp_kind !== want.kind || rsp_byte_value !== want.value ||
                   rsp_last !== want.last)
                  note_fault($sformatf(
                     "result %0d: expected kind %0d value %02h last %0b, got %0d %02h %0b",
                     results_seen, want.kind, want.value, want.last,
                     rsp_kind, rsp_byte_value, rsp_last));
            end
            results_seen++;
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles == WATCHDOG) begin
            $display("[telnet_iac_option_negotiator] ERROR");
            $finish;
         end
      end
   end

endmodule
